>>> sv/hrl_pkg.sv
package hrl_pkg;

  localparam int LINE_DEPTH = 256;
  localparam int LINE_AW    = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
  // wide enough for an 8-bit read index and for base + index before the wrap
  localparam int WIDE_W     = ((LINE_AW > 8) ? LINE_AW : 8) + 1;

  localparam int SUM_W      = 32;

  localparam int RQ_DEPTH   = 2;
  localparam int RQ_AW      = (RQ_DEPTH > 1) ? $clog2(RQ_DEPTH) : 1;
  localparam int RQ_LW      = $clog2(RQ_DEPTH + 1);

  localparam int CFG_AW     = 5;
  localparam int CFG_DW     = 32;

  typedef enum logic [2:0] {
    REG_LOWER_BOUND  = 3'd0,
    REG_UPPER_BOUND  = 3'd1,
    REG_STEP_SIZE    = 3'd2,
    REG_OUTER_PERIOD = 3'd3,
    REG_INNER_PERIOD = 3'd4,
    REG_DOWN_DWELL   = 3'd5,
    REG_UP_DWELL     = 3'd6
  } reg_idx_t;

  localparam logic [7:0]  RST_LOWER_BOUND  = 8'd0;
  localparam logic [7:0]  RST_UPPER_BOUND  = 8'd255;
  localparam logic [7:0]  RST_STEP_SIZE    = 8'd1;
  localparam logic [15:0] RST_OUTER_PERIOD = 16'd1;
  localparam logic [15:0] RST_INNER_PERIOD = 16'd1;
  localparam logic [15:0] RST_DOWN_DWELL   = 16'd0;
  localparam logic [15:0] RST_UP_DWELL     = 16'd0;

  typedef struct packed {
    logic [7:0]  lower_bound;
    logic [7:0]  upper_bound;
    logic [7:0]  step_size;
    logic [15:0] outer_period;
    logic [15:0] inner_period;
    logic [15:0] down_dwell;
    logic [15:0] up_dwell;
  } cfg_t;

  typedef struct packed {
    logic       paused;
    logic [7:0] read_index;
  } tick_t;

  typedef struct packed {
    logic [7:0]       head_value;
    logic [7:0]       read_data;
    logic [SUM_W-1:0] step_sum;
    logic             shifted;
  } result_t;

  // what the tick stage hands to the read-return stage
  typedef struct packed {
    logic [7:0]       head;
    logic [SUM_W-1:0] sum;
    logic             shifted;
    logic             use_head;
    logic             use_mem;
    logic             use_fwd;
    logic [7:0]       fwd_data;
  } stage_t;

endpackage

>>> sv/hrl_regs.sv
module hrl_regs import hrl_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic     wr;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[CFG_AW-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.lower_bound  <= RST_LOWER_BOUND;
      cfg.upper_bound  <= RST_UPPER_BOUND;
      cfg.step_size    <= RST_STEP_SIZE;
      cfg.outer_period <= RST_OUTER_PERIOD;
      cfg.inner_period <= RST_INNER_PERIOD;
      cfg.down_dwell   <= RST_DOWN_DWELL;
      cfg.up_dwell     <= RST_UP_DWELL;
    end else if (wr) begin
      case (idx)
        REG_LOWER_BOUND:  cfg.lower_bound  <= pwdata[7:0];
        REG_UPPER_BOUND:  cfg.upper_bound  <= pwdata[7:0];
        REG_STEP_SIZE:    cfg.step_size    <= pwdata[7:0];
        REG_OUTER_PERIOD: cfg.outer_period <= pwdata[15:0];
        REG_INNER_PERIOD: cfg.inner_period <= pwdata[15:0];
        REG_DOWN_DWELL:   cfg.down_dwell   <= pwdata[15:0];
        REG_UP_DWELL:     cfg.up_dwell     <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_LOWER_BOUND:  prdata = {24'd0, cfg.lower_bound};
      REG_UPPER_BOUND:  prdata = {24'd0, cfg.upper_bound};
      REG_STEP_SIZE:    prdata = {24'd0, cfg.step_size};
      REG_OUTER_PERIOD: prdata = {16'd0, cfg.outer_period};
      REG_INNER_PERIOD: prdata = {16'd0, cfg.inner_period};
      REG_DOWN_DWELL:   prdata = {16'd0, cfg.down_dwell};
      REG_UP_DWELL:     prdata = {16'd0, cfg.up_dwell};
      default:          prdata = '0;
    endcase
  end

endmodule

>>> sv/hrl_ram.sv
module hrl_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> sv/hrl_ctrl.sv
module hrl_ctrl import hrl_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               accept,
  input  tick_t              tick,
  output logic               mem_we,
  output logic [LINE_AW-1:0] mem_waddr,
  output logic [7:0]         mem_wdata,
  output logic [LINE_AW-1:0] mem_raddr,
  output stage_t             stage_next
);

  logic [15:0]        outer_count, outer_count_next;
  logic [15:0]        inner_count, inner_count_next;
  logic [15:0]        dwell_count, dwell_count_next;
  logic [7:0]         direction, direction_next;
  logic [7:0]         head, head_next;
  logic [SUM_W-1:0]   sum, sum_next;
  logic [LINE_AW-1:0] base, base_next;
  logic [LINE_AW-1:0] fill, fill_next;

  logic               advance, shift, outer_fire, inner_fire;
  logic [WIDE_W-1:0]  idx_w, addr_sum;
  logic               in_range, idx_zero;

  assign advance    = accept & ~tick.paused;
  assign outer_fire = (outer_count == 16'd0);
  assign inner_fire = (inner_count == 16'd0);
  assign shift      = advance & outer_fire;

  always_comb begin
    outer_count_next = outer_count;
    inner_count_next = inner_count;
    dwell_count_next = dwell_count;
    direction_next   = direction;
    head_next        = head;
    sum_next         = sum;
    base_next        = base;
    fill_next        = fill;

    if (advance) begin
      outer_count_next = (outer_fire ? cfg.outer_period : outer_count) - 16'd1;
    end

    if (shift) begin
      // line moves away from the head: the base pointer steps back one slot
      base_next = (base == '0) ? LINE_AW'(LINE_DEPTH - 1) : base - LINE_AW'(1);
      fill_next = (fill == LINE_AW'(LINE_DEPTH - 1)) ? fill : fill + LINE_AW'(1);
      inner_count_next = (inner_fire ? cfg.inner_period : inner_count) - 16'd1;

      if (inner_fire) begin
        if (dwell_count != 16'd0) begin
          dwell_count_next = dwell_count - 16'd1;
        end else begin
          // lower bound wins when the bounds cross
          if (head <= cfg.lower_bound) begin
            direction_next   = cfg.step_size;
            dwell_count_next = cfg.up_dwell;
          end else if (head >= cfg.upper_bound) begin
            direction_next   = 8'd0 - cfg.step_size;
            dwell_count_next = cfg.down_dwell;
          end
          head_next = head + direction_next;
          sum_next  = sum + SUM_W'(cfg.step_size);
        end
      end
    end
  end

  // old head lands where the base was, which is entry one after the shift
  assign mem_we    = shift;
  assign mem_waddr = base;
  assign mem_wdata = head;

  always_comb begin
    idx_w    = WIDE_W'(tick.read_index);
    in_range = (idx_w < WIDE_W'(LINE_DEPTH));
    idx_zero = (tick.read_index == 8'd0);
    addr_sum = WIDE_W'(base_next) + idx_w;
    if (addr_sum >= WIDE_W'(LINE_DEPTH)) begin
      addr_sum = addr_sum - WIDE_W'(LINE_DEPTH);
    end
    mem_raddr = addr_sum[LINE_AW-1:0];

    stage_next.head     = head_next;
    stage_next.sum      = sum_next;
    stage_next.shifted  = shift;
    stage_next.use_head = idx_zero;
    // entries beyond the fill count were never written and read as zero
    stage_next.use_mem  = ~idx_zero & in_range & (idx_w <= WIDE_W'(fill_next));
    // read of the slot written in the same cycle
    stage_next.use_fwd  = stage_next.use_mem & shift & (mem_raddr == base);
    stage_next.fwd_data = head;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      outer_count <= '0;
      inner_count <= '0;
      dwell_count <= '0;
      direction   <= '0;
      head        <= '0;
      sum         <= '0;
      base        <= '0;
      fill        <= '0;
    end else begin
      outer_count <= outer_count_next;
      inner_count <= inner_count_next;
      dwell_count <= dwell_count_next;
      direction   <= direction_next;
      head        <= head_next;
      sum         <= sum_next;
      base        <= base_next;
      fill        <= fill_next;
    end
  end

endmodule

>>> sv/hrl_outq.sv
module hrl_outq import hrl_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  result_t          push_data,
  input  logic             pop,
  output logic             result_valid,
  output result_t          result,
  output logic [RQ_LW-1:0] level
);

  result_t            q [RQ_DEPTH];
  logic [RQ_AW-1:0]   wr_ptr, rd_ptr;

  function automatic logic [RQ_AW-1:0] ptr_inc(input logic [RQ_AW-1:0] p);
    ptr_inc = (p == RQ_AW'(RQ_DEPTH - 1)) ? '0 : p + RQ_AW'(1);
  endfunction

  assign result_valid = (level != '0);
  assign result       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      level <= level + RQ_LW'(push) - RQ_LW'(pop);
    end
  end

endmodule

>>> sv/bouncing_ramp_history_line.sv
// Bouncing ramp with a 256-entry history line. A tick can be accepted every
// clock while the result queue has room. Its result is registered through the
// history RAM read and then the load of the two-entry result queue. With the
// consumer taking a result every clock, the queue holds one result and one
// transaction is in flight. tick_ready follows this cycle's result_ready, so
// a result stall then also holds off input. The line lives in a
// synchronous RAM with one write port and one read port, used as a circular
// buffer: a shift only moves the base pointer and writes the old head into
// one slot, while the head itself is held in a register. A fill count marks
// which entries were written since reset, and unwritten entries read as zero,
// so no clearing pass is needed after reset. A read of the slot written by
// the same tick is forwarded from the head register.
module bouncing_ramp_history_line import hrl_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  input  logic              tick_valid,
  output logic              tick_ready,
  input  tick_t             tick,
  output logic              result_valid,
  input  logic              result_ready,
  output result_t           result
);

  cfg_t               cfg;
  logic               accept, pop;
  logic               mem_we;
  logic [LINE_AW-1:0] mem_waddr, mem_raddr;
  logic [7:0]         mem_wdata, mem_rdata;
  stage_t             stage_next, s1;
  logic               s1_valid;
  result_t            push_data;
  logic [RQ_LW-1:0]   level;
  logic [RQ_LW:0]     occupancy;

  assign accept = tick_valid & tick_ready;
  assign pop    = result_valid & result_ready;

  // room for the transaction in flight plus this one after the pop
  assign occupancy  = (RQ_LW + 1)'(level) + (RQ_LW + 1)'(s1_valid) - (RQ_LW + 1)'(pop);
  assign tick_ready = (occupancy < (RQ_LW + 1)'(RQ_DEPTH));

  hrl_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  hrl_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .accept     (accept),
    .tick       (tick),
    .mem_we     (mem_we),
    .mem_waddr  (mem_waddr),
    .mem_wdata  (mem_wdata),
    .mem_raddr  (mem_raddr),
    .stage_next (stage_next)
  );

  hrl_ram #(
    .DEPTH (LINE_DEPTH),
    .WIDTH (8)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (accept),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1 <= stage_next;
    end
  end

  always_comb begin
    push_data.head_value = s1.head;
    push_data.step_sum   = s1.sum;
    push_data.shifted    = s1.shifted;
    if (s1.use_head) begin
      push_data.read_data = s1.head;
    end else if (s1.use_fwd) begin
      push_data.read_data = s1.fwd_data;
    end else if (s1.use_mem) begin
      push_data.read_data = mem_rdata;
    end else begin
      push_data.read_data = 8'd0;
    end
  end

  hrl_outq u_outq (
    .clk          (clk),
    .rst          (rst),
    .push         (s1_valid),
    .push_data    (push_data),
    .pop          (pop),
    .result_valid (result_valid),
    .result       (result),
    .level        (level)
  );

endmodule
